@@ src/assert_macros.svh @@
// Assertion macros used by the connection limit table top level.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition at one edge forces another at the next edge.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pacl_pkg.sv @@
// Shared types and codes for the per-address connection limit table.
// Used by pacl_cell and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pacl_pkg;

    localparam int ADDR_W    = 32;
    localparam int LIMIT_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNT_O_W = 16;
    localparam int USED_W    = 6;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [COUNT_O_W-1:0] count_after;
        logic [USED_W-1:0]    entries_used;
    } t_out_item;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic capture;  // register compare flags against the held key
        logic apply;    // commit the table update this cycle
        logic insert;   // open a slot at the insert point, shift up
        logic remove;   // close the matching slot, shift down
        logic inc;      // bump the matching count
        logic dec;      // lower the matching count
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ src/pacl_cell.sv @@
// One table slot: address, connection count and registered compare flags.
// Depends on pacl_pkg; neighbors hand address and count across on shifts.
`timescale 1ns / 1ps
`default_nettype none

module pacl_cell #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pacl_pkg::t_cell_cmd           i_cmd,
    input  wire logic [pacl_pkg::ADDR_W-1:0]   i_key,
    input  wire logic                          i_occupied,
    input  wire logic [pacl_pkg::ADDR_W-1:0]   i_prev_addr,
    input  wire logic [COUNT_BITS-1:0]         i_prev_count,
    input  wire logic                          i_prev_lt,
    input  wire logic [pacl_pkg::ADDR_W-1:0]   i_next_addr,
    input  wire logic [COUNT_BITS-1:0]         i_next_count,
    output logic      [pacl_pkg::ADDR_W-1:0]   o_addr,
    output logic      [COUNT_BITS-1:0]         o_count,
    output logic                               o_lt,
    output logic                               o_eq
);
    import pacl_pkg::*;

    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_lt, r_eq;

    always_comb begin
        n_addr  = r_addr;
        n_count = r_count;
        if (i_cmd.apply) begin
            if (i_cmd.insert) begin
                // Below the insert point: hold. At it: load key. Above: shift up.
                if (!r_lt) begin
                    if (i_prev_lt) begin
                        n_addr  = i_key;
                        n_count = COUNT_BITS'(1);
                    end else begin
                        n_addr  = i_prev_addr;
                        n_count = i_prev_count;
                    end
                end
            end else if (i_cmd.remove) begin
                if (!r_lt) begin
                    n_addr  = i_next_addr;
                    n_count = i_next_count;
                end
            end else if (i_cmd.inc) begin
                if (r_eq) begin
                    n_count = r_count + COUNT_BITS'(1);
                end
            end else if (i_cmd.dec) begin
                if (r_eq) begin
                    n_count = r_count - COUNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_count <= n_count;
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_cmd.capture) begin
            r_lt <= i_occupied && (r_addr < i_key);
            r_eq <= i_occupied && (r_addr == i_key);
        end
    end

    assign o_addr  = r_addr;
    assign o_count = r_count;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

`default_nettype wire

@@ src/per_address_connection_limit_table.sv @@
// Per-address connection limit table: a sorted row of address/count cells.
// Depends on pacl_pkg, pacl_cell and assert_macros.svh.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall, payload i_in_item) carries one
//   transaction per request: op (acquire or release) and a 32-bit address.
//   Result channel (o_out_valid / i_out_stall, payload o_out_item) returns
//   exactly one transaction per request: status, count after the request and
//   the number of entries in use.
//   Limit channel (i_cfg_valid / o_cfg_ready, i_cfg_data) writes the
//   per-address limit; zero means no limit. Write it only while idle.
// Timing:
//   An accepted request is compared against every cell (all cells in parallel)
//   in S_COMPARE, which registers the flags, and S_UPDATE then commits the table
//   update and loads the result register once the result slot is free. The
//   next request can be accepted in that same cycle, not before, since each
//   request must pass the compare and then the shift through the cell row.
// Reset:
//   Clears occupancy, the limit and the result valid; cell contents stay
//   undefined and are never read beyond occupancy.
// Stall:
//   While a result waits under i_out_stall, a pending update is held in S_UPDATE
//   and o_in_stall stays high there; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module per_address_connection_limit_table #(
    parameter int TABLE_ENTRIES = 32,
    parameter int COUNT_BITS    = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire pacl_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output pacl_pkg::t_out_item                 o_out_item,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [pacl_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import pacl_pkg::*;

    localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_UPDATE
    } t_state;

    t_state                r_state, n_state;
    logic                  r_op, n_op;
    logic [ADDR_W-1:0]     r_key, n_key;
    logic [OCC_W-1:0]      r_occ, n_occ;
    logic [LIMIT_W-1:0]    r_limit, n_limit;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic [ADDR_W-1:0]     cell_addr  [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] cell_count [TABLE_ENTRIES];
    logic [ADDR_W-1:0]     prev_addr  [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] prev_count [TABLE_ENTRIES];
    logic [ADDR_W-1:0]     next_addr  [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] next_count [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] lt_vec, eq_vec, prev_lt, occ_vec;

    t_cell_cmd             cmd;
    logic                  out_free, in_accept, finish;
    logic                  found, refused, table_full;
    logic [COUNT_BITS-1:0] match_count;
    t_out_item             result;
    logic [OCC_W-1:0]      occ_after;

    // ------------------------------------------------------------------
    // Cell row. Each cell sees its neighbors' contents for shifts.
    // ------------------------------------------------------------------
    for (genvar g_i = 0; g_i < TABLE_ENTRIES; g_i++) begin : g_cell
        assign occ_vec[g_i] = (r_occ > OCC_W'(g_i));

        if (g_i == 0) begin : g_head
            assign prev_addr[g_i]  = '0;
            assign prev_count[g_i] = '0;
            assign prev_lt[g_i]    = 1'b1;   // nothing below the first cell
        end else begin : g_body
            assign prev_addr[g_i]  = cell_addr[g_i-1];
            assign prev_count[g_i] = cell_count[g_i-1];
            assign prev_lt[g_i]    = lt_vec[g_i-1];
        end

        if (g_i == TABLE_ENTRIES - 1) begin : g_tail
            assign next_addr[g_i]  = cell_addr[g_i];
            assign next_count[g_i] = cell_count[g_i];
        end else begin : g_inner
            assign next_addr[g_i]  = cell_addr[g_i+1];
            assign next_count[g_i] = cell_count[g_i+1];
        end

        pacl_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_key        (r_key),
            .i_occupied   (occ_vec[g_i]),
            .i_prev_addr  (prev_addr[g_i]),
            .i_prev_count (prev_count[g_i]),
            .i_prev_lt    (prev_lt[g_i]),
            .i_next_addr  (next_addr[g_i]),
            .i_next_count (next_count[g_i]),
            .o_addr       (cell_addr[g_i]),
            .o_count      (cell_count[g_i]),
            .o_lt         (lt_vec[g_i]),
            .o_eq         (eq_vec[g_i])
        );
    end

    // ------------------------------------------------------------------
    // Match select: at most one cell flags equal, so an OR picks its count.
    // ------------------------------------------------------------------
    always_comb begin
        match_count = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match_count = match_count | (cell_count[i] & {COUNT_BITS{eq_vec[i]}});
        end
    end

    assign found      = |eq_vec;
    assign table_full = (r_occ >= OCC_W'(TABLE_ENTRIES));
    // Refuse at saturation, or when one more would pass a nonzero limit.
    assign refused    = (&match_count) ||
                        ((r_limit != '0) && (CMP_W'(match_count) >= CMP_W'(r_limit)));

    // Handshake glue.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign finish      = (r_state == S_UPDATE) && out_free;
    assign o_in_stall  = !((r_state == S_IDLE) || finish);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Decide the update and the result from the registered cell flags.
    // ------------------------------------------------------------------
    always_comb begin
        cmd         = '0;
        cmd.capture = (r_state == S_COMPARE);
        cmd.apply   = finish;
        occ_after   = r_occ;
        result      = '0;

        if (r_op == OP_RELEASE) begin
            if (!found) begin
                result.status = ST_ABSENT;
            end else if (match_count <= COUNT_BITS'(1)) begin
                // Last connection gone: drop the entry.
                cmd.remove    = 1'b1;
                occ_after     = r_occ - OCC_W'(1);
                result.status = ST_OK;
            end else begin
                cmd.dec            = 1'b1;
                result.status      = ST_OK;
                result.count_after = COUNT_O_W'(match_count - COUNT_BITS'(1));
            end
        end else if (found) begin
            if (refused) begin
                result.status      = ST_REFUSED;
                result.count_after = COUNT_O_W'(match_count);
            end else begin
                cmd.inc            = 1'b1;
                result.status      = ST_OK;
                result.count_after = COUNT_O_W'(match_count + COUNT_BITS'(1));
            end
        end else if (table_full) begin
            result.status = ST_FULL;
        end else begin
            cmd.insert         = 1'b1;
            occ_after          = r_occ + OCC_W'(1);
            result.status      = ST_OK;
            result.count_after = COUNT_O_W'(1);
        end
        result.entries_used = USED_W'(occ_after);
    end

    // ------------------------------------------------------------------
    // Sequencer next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_occ       = r_occ;
        n_limit     = r_limit;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (i_cfg_valid && o_cfg_ready) begin
            n_limit = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_COMPARE;
                end
            end
            S_COMPARE: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (finish) begin
                    n_occ       = occ_after;
                    n_out_valid = 1'b1;
                    n_out       = result;
                    n_state     = in_accept ? S_COMPARE : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (in_accept) begin
            n_op  = i_in_item.op;
            n_key = i_in_item.address;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_key <= n_key;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Checks on the cell row and the sequencer.
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_single_match, i_clk, i_rst_n, $onehot0(eq_vec), "more than one cell matches")
    `ASSERT_ALWAYS(a_lt_thermo, i_clk, i_rst_n, (lt_vec & (lt_vec + TABLE_ENTRIES'(1))) == '0, "below-key flags not contiguous from cell 0")
    `ASSERT_ALWAYS(a_occ_bound, i_clk, i_rst_n, r_occ <= OCC_W'(TABLE_ENTRIES), "occupancy beyond table size")
    `ASSERT_NEXT(a_accept_compare, i_clk, i_rst_n, in_accept, r_state == S_COMPARE, "accepted request did not enter compare")
    `ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, finish, o_out_valid, "finished request left no result")

endmodule

`default_nettype wire
